[rtl/core/cll_pkg.sv]
// Shared constants and types for the circular list with cursor.
package cll_pkg;

    localparam int CAPACITY_DEF   = 256;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int CMD_W          = 3;
    localparam int WORD_W         = 32;

    localparam logic [CMD_W-1:0] CMD_INS_TAIL = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INS_HEAD = 3'd1;
    localparam logic [CMD_W-1:0] CMD_FIRST    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_NEXT     = 3'd3;
    localparam logic [CMD_W-1:0] CMD_REMOVE   = 3'd4;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2,
        STAT_NOCUR = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_LINK,
        S_HOLD
    } state_t;

endpackage

[rtl/core/circular_list_with_cursor.sv]
// Circular singly linked list with a traversal cursor, held in a node pool.
//
// Input channel (in_valid / in_stall) carries one command item: cmd and data_in.
// Output channel (out_valid / out_stall) carries one result item per command:
// status, data_out and node_count after the command.
// The pool keeps a link memory (two read ports, one write port) and a data
// memory (one read port, one write port), both with registered read data.
// An item is accepted only in the idle state. The cycle of acceptance issues
// the link reads, the execute state resolves the command and reads the data at
// the new cursor, and the link state performs the second link write of an insert
// or a remove. Errors, unused commands and an insert into an empty list finish
// in the execute state, all others in the link state. An insert or a remove needs
// the link state for its two dependent accesses to the single write port of the
// link memory; the next item is accepted only after the last has finished.
// Results go into an output register; while the receiver stalls, a finished
// result waits in a holding register and no item is accepted until it moves on.
// Reset empties the list, the free chain and the output register at once; the
// memories need no clearing, as no read value is used before its entry is written.
module circular_list_with_cursor #(
    parameter int CAPACITY   = cll_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = cll_pkg::DATA_WIDTH_DEF,
    localparam int PW        = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    localparam int CW        = $clog2(CAPACITY + 1)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [cll_pkg::CMD_W-1:0]           cmd,
    input  logic signed [cll_pkg::WORD_W-1:0]   data_in,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [1:0]                          status,
    output logic signed [cll_pkg::WORD_W-1:0]   data_out,
    output logic [CW-1:0]                       node_count
);

    logic [PW-1:0]         link_mem [CAPACITY];
    logic [DATA_WIDTH-1:0] data_mem [CAPACITY];

    cll_pkg::state_t state_reg, state_next;

    logic [PW-1:0]  tail_reg, tail_next;
    logic           nonempty_reg, nonempty_next;
    logic [PW-1:0]  cursor_reg, cursor_next;
    logic [PW-1:0]  before_reg, before_next;
    logic           cv_reg, cv_next;
    logic           ra_reg, ra_next;
    logic [PW-1:0]  free_head_reg, free_head_next;
    logic [CW-1:0]  free_len_reg, free_len_next;
    logic [CW-1:0]  fresh_reg, fresh_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           out_valid_reg, out_valid_next;

    logic [cll_pkg::CMD_W-1:0]  cmd_reg, cmd_next;
    logic [cll_pkg::WORD_W-1:0] din_reg, din_next;
    logic [PW-1:0]              node_reg, node_next;
    cll_pkg::status_t           res_status_reg, res_status_next;
    logic [cll_pkg::WORD_W-1:0] res_data_reg, res_data_next;
    logic [CW-1:0]              res_count_reg, res_count_next;
    cll_pkg::status_t           out_status_reg, out_status_next;
    logic [cll_pkg::WORD_W-1:0] out_data_reg, out_data_next;
    logic [CW-1:0]              out_count_reg, out_count_next;

    logic [PW-1:0]         link_q0, link_q1;
    logic [DATA_WIDTH-1:0] data_q;
    logic [PW-1:0]         ra0, ra1, rd_addr;
    logic                  lw_en, dw_en;
    logic [PW-1:0]         lw_addr, lw_data, dw_addr;

    logic                       finish, go_link, out_free, accept;
    cll_pkg::status_t           fin_status;
    logic [cll_pkg::WORD_W-1:0] fin_data;
    logic [63:0]                rd_ext, din_ext;
    logic [cll_pkg::WORD_W-1:0] rd_word;
    logic [DATA_WIDTH-1:0]      wr_word;
    logic [PW-1:0]              new_node;
    logic                       have_free, have_fresh;

    assign in_stall   = (state_reg != cll_pkg::S_IDLE);
    assign accept     = in_valid && !in_stall;
    assign out_free   = !out_valid_reg || !out_stall;
    assign out_valid  = out_valid_reg;
    assign status     = out_status_reg;
    assign data_out   = out_data_reg;
    assign node_count = out_count_reg;

    assign rd_ext  = 64'($signed(data_q));
    assign rd_word = rd_ext[cll_pkg::WORD_W-1:0];
    assign din_ext = {32'd0, din_reg};
    assign wr_word = din_ext[DATA_WIDTH-1:0];

    assign have_free  = (free_len_reg != '0);
    assign have_fresh = (fresh_reg < CW'(CAPACITY));
    assign new_node   = have_free ? free_head_reg : fresh_reg[PW-1:0];

    always_ff @(posedge clk)
    begin
        if (lw_en)
        begin
            link_mem[lw_addr] <= lw_data;
        end
        link_q0 <= link_mem[ra0];
        link_q1 <= link_mem[ra1];
    end

    always_ff @(posedge clk)
    begin
        if (dw_en)
        begin
            data_mem[dw_addr] <= wr_word;
        end
        data_q <= data_mem[rd_addr];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cll_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = cll_pkg::S_EXEC;
                end
            end
            cll_pkg::S_EXEC:
            begin
                if (go_link)
                begin
                    state_next = cll_pkg::S_LINK;
                end
                else
                begin
                    state_next = out_free ? cll_pkg::S_IDLE : cll_pkg::S_HOLD;
                end
            end
            cll_pkg::S_LINK:
            begin
                state_next = out_free ? cll_pkg::S_IDLE : cll_pkg::S_HOLD;
            end
            cll_pkg::S_HOLD:
            begin
                if (out_free)
                begin
                    state_next = cll_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = cll_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        tail_next       = tail_reg;
        nonempty_next   = nonempty_reg;
        cursor_next     = cursor_reg;
        before_next     = before_reg;
        cv_next         = cv_reg;
        ra_next         = ra_reg;
        free_head_next  = free_head_reg;
        free_len_next   = free_len_reg;
        fresh_next      = fresh_reg;
        count_next      = count_reg;
        cmd_next        = cmd_reg;
        din_next        = din_reg;
        node_next       = node_reg;
        res_status_next = res_status_reg;
        res_data_next   = res_data_reg;
        res_count_next  = res_count_reg;
        out_status_next = out_status_reg;
        out_data_next   = out_data_reg;
        out_count_next  = out_count_reg;
        out_valid_next  = out_valid_reg && out_stall;
        ra0             = cursor_reg;
        ra1             = tail_reg;
        rd_addr         = cursor_reg;
        lw_en           = 1'b0;
        lw_addr         = node_reg;
        lw_data         = free_head_reg;
        dw_en           = 1'b0;
        dw_addr         = node_reg;
        finish          = 1'b0;
        go_link         = 1'b0;
        fin_status      = cll_pkg::STAT_OK;
        fin_data        = '0;

        case (state_reg)
            cll_pkg::S_IDLE:
            begin
                if (cmd == cll_pkg::CMD_INS_TAIL || cmd == cll_pkg::CMD_INS_HEAD)
                begin
                    ra0 = free_head_reg;
                end
                else if (cmd == cll_pkg::CMD_FIRST)
                begin
                    ra0 = tail_reg;
                end
                if (accept)
                begin
                    cmd_next = cmd;
                    din_next = data_in;
                end
            end
            cll_pkg::S_EXEC:
            begin
                rd_addr = link_q0;
                case (cmd_reg)
                    cll_pkg::CMD_INS_TAIL, cll_pkg::CMD_INS_HEAD:
                    begin
                        if (!have_free && !have_fresh)
                        begin
                            finish     = 1'b1;
                            fin_status = cll_pkg::STAT_FULL;
                        end
                        else
                        begin
                            if (have_free)
                            begin
                                free_head_next = link_q0;
                                free_len_next  = free_len_reg - CW'(1);
                            end
                            else
                            begin
                                fresh_next = fresh_reg + CW'(1);
                            end
                            node_next  = new_node;
                            dw_en      = 1'b1;
                            dw_addr    = new_node;
                            lw_en      = 1'b1;
                            lw_addr    = new_node;
                            lw_data    = nonempty_reg ? link_q1 : new_node;
                            count_next = count_reg + CW'(1);
                            cv_next    = 1'b0;
                            ra_next    = 1'b0;
                            if (nonempty_reg)
                            begin
                                go_link = 1'b1;
                            end
                            else
                            begin
                                tail_next     = new_node;
                                nonempty_next = 1'b1;
                                finish        = 1'b1;
                            end
                        end
                    end
                    cll_pkg::CMD_FIRST:
                    begin
                        if (!nonempty_reg)
                        begin
                            finish     = 1'b1;
                            fin_status = cll_pkg::STAT_EMPTY;
                        end
                        else
                        begin
                            before_next = tail_reg;
                            cursor_next = link_q0;
                            cv_next     = 1'b1;
                            ra_next     = 1'b1;
                            go_link     = 1'b1;
                        end
                    end
                    cll_pkg::CMD_NEXT:
                    begin
                        if (!nonempty_reg)
                        begin
                            finish     = 1'b1;
                            fin_status = cll_pkg::STAT_EMPTY;
                        end
                        else if (!cv_reg)
                        begin
                            finish     = 1'b1;
                            fin_status = cll_pkg::STAT_NOCUR;
                        end
                        else
                        begin
                            before_next = cursor_reg;
                            cursor_next = link_q0;
                            ra_next     = 1'b1;
                            go_link     = 1'b1;
                        end
                    end
                    cll_pkg::CMD_REMOVE:
                    begin
                        if (!nonempty_reg)
                        begin
                            finish     = 1'b1;
                            fin_status = cll_pkg::STAT_EMPTY;
                        end
                        else if (!ra_reg || !cv_reg)
                        begin
                            finish     = 1'b1;
                            fin_status = cll_pkg::STAT_NOCUR;
                        end
                        else
                        begin
                            res_data_next = rd_word;
                            node_next     = cursor_reg;
                            lw_en         = 1'b1;
                            lw_addr       = before_reg;
                            lw_data       = link_q0;
                            cursor_next   = before_reg;
                            free_len_next = free_len_reg + CW'(1);
                            ra_next       = 1'b0;
                            go_link       = 1'b1;
                            if (count_reg != '0)
                            begin
                                count_next = count_reg - CW'(1);
                            end
                            if (cursor_reg == tail_reg)
                            begin
                                if (link_q0 == cursor_reg)
                                begin
                                    nonempty_next = 1'b0;
                                    cv_next       = 1'b0;
                                    count_next    = '0;
                                    tail_next     = '0;
                                end
                                else
                                begin
                                    tail_next = before_reg;
                                end
                            end
                        end
                    end
                    default:
                    begin
                        finish = 1'b1;
                    end
                endcase
            end
            cll_pkg::S_LINK:
            begin
                finish = 1'b1;
                case (cmd_reg)
                    cll_pkg::CMD_INS_TAIL, cll_pkg::CMD_INS_HEAD:
                    begin
                        lw_en   = 1'b1;
                        lw_addr = tail_reg;
                        lw_data = node_reg;
                        if (cmd_reg == cll_pkg::CMD_INS_TAIL)
                        begin
                            tail_next = node_reg;
                        end
                    end
                    cll_pkg::CMD_FIRST, cll_pkg::CMD_NEXT:
                    begin
                        fin_data = rd_word;
                    end
                    cll_pkg::CMD_REMOVE:
                    begin
                        lw_en          = 1'b1;
                        lw_addr        = node_reg;
                        lw_data        = free_head_reg;
                        free_head_next = node_reg;
                        fin_data       = res_data_reg;
                    end
                    default:
                    begin
                        fin_data = '0;
                    end
                endcase
            end
            cll_pkg::S_HOLD:
            begin
                if (out_free)
                begin
                    out_status_next = res_status_reg;
                    out_data_next   = res_data_reg;
                    out_count_next  = res_count_reg;
                    out_valid_next  = 1'b1;
                end
            end
            default:
            begin
                finish = 1'b0;
            end
        endcase

        if (finish)
        begin
            if (out_free)
            begin
                out_status_next = fin_status;
                out_data_next   = fin_data;
                out_count_next  = count_next;
                out_valid_next  = 1'b1;
            end
            else
            begin
                res_status_next = fin_status;
                res_data_next   = fin_data;
                res_count_next  = count_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cll_pkg::S_IDLE;
            tail_reg      <= '0;
            nonempty_reg  <= 1'b0;
            cursor_reg    <= '0;
            before_reg    <= '0;
            cv_reg        <= 1'b0;
            ra_reg        <= 1'b0;
            free_head_reg <= '0;
            free_len_reg  <= '0;
            fresh_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tail_reg      <= tail_next;
            nonempty_reg  <= nonempty_next;
            cursor_reg    <= cursor_next;
            before_reg    <= before_next;
            cv_reg        <= cv_next;
            ra_reg        <= ra_next;
            free_head_reg <= free_head_next;
            free_len_reg  <= free_len_next;
            fresh_reg     <= fresh_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        din_reg        <= din_next;
        node_reg       <= node_next;
        res_status_reg <= res_status_next;
        res_data_reg   <= res_data_next;
        res_count_reg  <= res_count_next;
        out_status_reg <= out_status_next;
        out_data_reg   <= out_data_next;
        out_count_reg  <= out_count_next;
    end

endmodule

[tb/circular_list_with_cursor_test.sv]
// Self-checking testbench for the circular list with cursor: commands against a list model.
module circular_list_with_cursor_test;

    localparam int POOL_SIZE = cll_pkg::CAPACITY_DEF;

    typedef struct packed {
        cll_pkg::status_t st;
        logic [31:0]      dout;
        logic [8:0]       cnt;
    } list_result_t;

    logic                              clk;
    logic                              rst_n;
    logic                              in_valid;
    logic                              in_stall;
    logic [cll_pkg::CMD_W-1:0]         cmd;
    logic signed [cll_pkg::WORD_W-1:0] data_in;
    logic                              out_valid;
    logic                              out_stall;
    logic [1:0]                        status;
    logic signed [cll_pkg::WORD_W-1:0] data_out;
    logic [8:0]                        node_count;

    // list model state
    logic [7:0]  link_mem [POOL_SIZE];
    logic [31:0] word_mem [POOL_SIZE];
    logic [7:0]  tail_node = '0;
    logic [7:0]  cur_node = '0;
    logic [7:0]  prev_node = '0;
    logic [7:0]  free_top = '0;
    logic [8:0]  free_len = '0;
    logic [8:0]  fresh_used = '0;
    logic [8:0]  list_len = '0;
    bit          list_live = 1'b0;
    bit          cur_ok = 1'b0;
    bit          may_remove = 1'b0;

    list_result_t expected_results[$];
    list_result_t want_result;

    int  errors = 0;
    int  items_sent = 0;
    int  results_seen = 0;
    int  full_rejects = 0;
    int  removals = 0;
    int  stall_left = 0;
    bit  gaps_off = 1'b0;

    circular_list_with_cursor dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cmd        (cmd),
        .data_in    (data_in),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .data_out   (data_out),
        .node_count (node_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic list_result_t apply_list_cmd(logic [2:0] c, logic [31:0] d);
        list_result_t r;
        logic [7:0]   n;
        logic [7:0]   rm;
        logic [7:0]   bk;
        bit           got;
        r.st   = cll_pkg::STAT_OK;
        r.dout = '0;
        case (c)
            cll_pkg::CMD_INS_TAIL, cll_pkg::CMD_INS_HEAD:
            begin
                got = 1'b1;
                n   = '0;
                if (free_len > 0)
                begin
                    n        = free_top;
                    free_top = link_mem[n];
                    free_len = free_len - 9'd1;
                end
                else if (fresh_used < POOL_SIZE)
                begin
                    n          = fresh_used[7:0];
                    fresh_used = fresh_used + 9'd1;
                end
                else
                begin
                    got = 1'b0;
                end
                if (!got)
                begin
                    r.st = cll_pkg::STAT_FULL;
                end
                else
                begin
                    word_mem[n] = d;
                    if (!list_live)
                    begin
                        link_mem[n] = n;
                        tail_node   = n;
                        list_live   = 1'b1;
                    end
                    else
                    begin
                        link_mem[n]         = link_mem[tail_node];
                        link_mem[tail_node] = n;
                        if (c == cll_pkg::CMD_INS_TAIL)
                            tail_node = n;
                    end
                    list_len   = list_len + 9'd1;
                    cur_ok     = 1'b0;
                    may_remove = 1'b0;
                end
            end
            cll_pkg::CMD_FIRST:
            begin
                if (!list_live)
                begin
                    r.st = cll_pkg::STAT_EMPTY;
                end
                else
                begin
                    prev_node  = tail_node;
                    cur_node   = link_mem[prev_node];
                    cur_ok     = 1'b1;
                    may_remove = 1'b1;
                    r.dout     = word_mem[cur_node];
                end
            end
            cll_pkg::CMD_NEXT:
            begin
                if (!list_live)
                begin
                    r.st = cll_pkg::STAT_EMPTY;
                end
                else if (!cur_ok)
                begin
                    r.st = cll_pkg::STAT_NOCUR;
                end
                else
                begin
                    prev_node  = cur_node;
                    cur_node   = link_mem[prev_node];
                    may_remove = 1'b1;
                    r.dout     = word_mem[cur_node];
                end
            end
            cll_pkg::CMD_REMOVE:
            begin
                if (!list_live)
                begin
                    r.st = cll_pkg::STAT_EMPTY;
                end
                else if (!may_remove || !cur_ok)
                begin
                    r.st = cll_pkg::STAT_NOCUR;
                end
                else
                begin
                    rm     = cur_node;
                    bk     = prev_node;
                    r.dout = word_mem[rm];
                    if (rm == tail_node)
                    begin
                        if (link_mem[rm] == rm)
                            list_live = 1'b0;
                        else
                            tail_node = bk;
                    end
                    link_mem[bk] = link_mem[rm];
                    cur_node     = bk;
                    link_mem[rm] = free_top;
                    free_top     = rm;
                    free_len     = free_len + 9'd1;
                    if (list_len > 0)
                        list_len = list_len - 9'd1;
                    may_remove = 1'b0;
                    if (!list_live)
                    begin
                        cur_ok    = 1'b0;
                        list_len  = '0;
                        tail_node = '0;
                    end
                end
            end
            default:
            begin
            end
        endcase
        r.cnt = list_len;
        return r;
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        if (r < 93)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            3: return 32'h0000_0000;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [2:0] rand_insert();
        return ($urandom_range(0, 1) == 1) ? cll_pkg::CMD_INS_HEAD : cll_pkg::CMD_INS_TAIL;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch at result %0d: %s got %0h expected %0h",
                 results_seen, what, got, want);
        errors++;
    endtask

    task automatic send_cmd(logic [2:0] c, logic [31:0] d);
        list_result_t r;
        int           gap;
        gap = (!gaps_off && $urandom_range(0, 1) == 1) ? idle_len() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= c;
        data_in  <= d;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        r = apply_list_cmd(c, d);
        expected_results.push_back(r);
        items_sent++;
        if (r.st == cll_pkg::STAT_FULL)
            full_rejects++;
        if (c == cll_pkg::CMD_REMOVE && r.st == cll_pkg::STAT_OK)
            removals++;
    endtask

    // hold the receiver off in random bursts
    always @(posedge clk)
    begin
        if (stall_left > 0)
            stall_left--;
        else if (!gaps_off && $urandom_range(0, 3) == 0)
            stall_left = idle_len();
        out_stall <= (stall_left > 0);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                report_mismatch("result with nothing pending", 32'(status), '0);
            end
            else
            begin
                want_result = expected_results.pop_front();
                if (status !== want_result.st)
                    report_mismatch("status", 32'(status), 32'(want_result.st));
                if (data_out !== want_result.dout)
                    report_mismatch("data_out", data_out, want_result.dout);
                if (node_count !== want_result.cnt)
                    report_mismatch("node_count", 32'(node_count), 32'(want_result.cnt));
            end
            results_seen++;
        end
    end

    task automatic check_directed_cases();
        send_cmd(cll_pkg::CMD_FIRST, 32'h1234_5678);
        send_cmd(cll_pkg::CMD_NEXT, 32'h0);
        send_cmd(cll_pkg::CMD_REMOVE, 32'hffff_ffff);
        send_cmd(3'd5, 32'hdead_beef);
        send_cmd(3'd6, 32'h0);
        send_cmd(3'd7, 32'hffff_ffff);
        send_cmd(cll_pkg::CMD_INS_TAIL, 32'h7fff_ffff);
        send_cmd(cll_pkg::CMD_NEXT, 32'h0);
        send_cmd(cll_pkg::CMD_REMOVE, 32'h0);
        send_cmd(cll_pkg::CMD_INS_HEAD, 32'h8000_0000);
        send_cmd(cll_pkg::CMD_INS_TAIL, 32'hffff_ffff);
        send_cmd(cll_pkg::CMD_INS_HEAD, 32'h0000_0000);
        send_cmd(cll_pkg::CMD_FIRST, 32'h0);
        send_cmd(cll_pkg::CMD_NEXT, 32'h0);
        send_cmd(cll_pkg::CMD_NEXT, 32'h0);
        send_cmd(cll_pkg::CMD_NEXT, 32'h0);
        send_cmd(cll_pkg::CMD_REMOVE, 32'h0);
        send_cmd(cll_pkg::CMD_REMOVE, 32'h0);
        send_cmd(cll_pkg::CMD_NEXT, 32'h0);
        send_cmd(cll_pkg::CMD_REMOVE, 32'h0);
        send_cmd(cll_pkg::CMD_INS_TAIL, 32'h5555_aaaa);
        send_cmd(cll_pkg::CMD_NEXT, 32'h0);
        while (list_len > 0)
        begin
            send_cmd(cll_pkg::CMD_FIRST, rand_word());
            send_cmd(cll_pkg::CMD_REMOVE, rand_word());
        end
        send_cmd(cll_pkg::CMD_NEXT, 32'h0);
    endtask

    task automatic check_random_traffic(int n_items);
        int target;
        int pick;
        int steps;
        target = items_sent + n_items;
        while (items_sent < target)
        begin
            gaps_off <= ((items_sent / 120) % 3 == 2);
            pick = $urandom_range(0, 99);
            if (pick < 10)
            begin
                send_cmd(3'($urandom_range(0, 7)), rand_word());
            end
            else if (list_len < 2 || (pick < 45 && list_len < 48))
            begin
                repeat ($urandom_range(1, 4)) send_cmd(rand_insert(), rand_word());
            end
            else
            begin
                send_cmd(cll_pkg::CMD_FIRST, rand_word());
                if ($urandom_range(0, 9) == 0)
                    steps = $urandom_range(0, list_len + 2);
                else
                    steps = $urandom_range(0, 4);
                repeat (steps) send_cmd(cll_pkg::CMD_NEXT, rand_word());
                send_cmd(cll_pkg::CMD_REMOVE, rand_word());
                case ($urandom_range(0, 3))
                    0: send_cmd(cll_pkg::CMD_REMOVE, rand_word());
                    1:
                    begin
                        send_cmd(cll_pkg::CMD_NEXT, rand_word());
                        send_cmd(cll_pkg::CMD_REMOVE, rand_word());
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    endtask

    task automatic check_pool_exhaustion();
        gaps_off <= 1'b0;
        while (list_len < POOL_SIZE)
            send_cmd(rand_insert(), rand_word());
        repeat (3) send_cmd(rand_insert(), rand_word());
        send_cmd(cll_pkg::CMD_FIRST, rand_word());
        while (list_len > POOL_SIZE - 40)
        begin
            repeat ($urandom_range(0, 2)) send_cmd(cll_pkg::CMD_NEXT, rand_word());
            send_cmd(cll_pkg::CMD_REMOVE, rand_word());
            send_cmd(cll_pkg::CMD_NEXT, rand_word());
        end
        send_cmd(cll_pkg::CMD_REMOVE, rand_word());
        repeat (3) send_cmd(rand_insert(), rand_word());
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        cmd       <= '0;
        data_in   <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        check_directed_cases();
        check_random_traffic(350);
        check_pool_exhaustion();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        $display("summary: %0d commands sent, %0d results checked, %0d mismatches",
                 items_sent, results_seen, errors);
        $display("summary: %0d removals, %0d inserts rejected on a full pool",
                 removals, full_rejects);
        if (errors == 0)
            $display("circular_list_with_cursor_test: PASS");
        else
            $display("circular_list_with_cursor_test: FAIL");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("circular_list_with_cursor_test: FAIL");
        $finish;
    end

endmodule
